// ===== src/sjf_pkg.sv =====
// Shared constants, codes and state types of the shortest-job-first ready table scheduler.
package sjf_pkg;

  localparam int unsigned READY_SLOTS_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  localparam int unsigned EST_W     = 16;
  localparam int unsigned ALPHA_W   = 7;
  localparam int unsigned SUM_W     = 23;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 4;

  localparam logic [ALPHA_W-1:0] PERCENT_SCALE = 7'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 7'd50;
  localparam logic [EST_W-1:0]   INIT_RESET    = 16'd5;
  localparam logic [EST_W-1:0]   EST_MAX       = 16'hFFFF;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ALPHA = 2'd1;
  localparam logic [1:0] REG_INIT  = 2'd2;

  typedef enum logic [2:0] {
    CMD_ADMIT    = 3'd0,
    CMD_REQUEUE  = 3'd1,
    CMD_SCHEDULE = 3'd2,
    CMD_TICK     = 3'd3,
    CMD_RELEASE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_SHIFT  = 7'b0010000,
    S_BLEND  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } fsm_e;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_ADD  = 4'b0100,
    B_DIV  = 4'b1000
  } blend_e;

endpackage

// ===== src/sjf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sjf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sjf_blend.sv =====
// Exponential-average estimate unit: one shared multiplier, two products, then divide by 100.
module sjf_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sjf_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic [sjf_pkg::EST_W-1:0]    real_i,
  input  logic [sjf_pkg::EST_W-1:0]    prev_i,
  output logic                         done_o,
  output logic [sjf_pkg::EST_W-1:0]    result_o
);

  localparam int unsigned OP_W     = 24;
  localparam int unsigned PROD_W   = 2 * OP_W;
  localparam int unsigned RECIP_SH = 30;
  // ceil(2^30 / 100): quotient is exact for every sum below 2^23
  localparam logic [OP_W-1:0] RECIP_100 = 24'd10737419;

  sjf_pkg::blend_e                state_q, state_d;
  logic [sjf_pkg::ALPHA_W-1:0]    a_q, a_d;
  logic [sjf_pkg::EST_W-1:0]      real_q, real_d;
  logic [sjf_pkg::EST_W-1:0]      prev_q, prev_d;
  logic [sjf_pkg::SUM_W-1:0]      rem_q, rem_d;
  logic [OP_W-1:0]                mul_a, mul_b;
  logic [PROD_W-1:0]              prod;

  assign prod     = mul_a * mul_b;
  assign done_o   = (state_q == sjf_pkg::B_DIV);
  assign result_o = prod[RECIP_SH +: sjf_pkg::EST_W];

  // operand select for the one multiplier
  always_comb begin
    unique case (state_q)
      sjf_pkg::B_MUL: begin
        mul_a = OP_W'(a_q);
        mul_b = OP_W'(real_q);
      end
      sjf_pkg::B_ADD: begin
        mul_a = OP_W'(sjf_pkg::PERCENT_SCALE - a_q);
        mul_b = OP_W'(prev_q);
      end
      default: begin
        mul_a = OP_W'(rem_q);
        mul_b = RECIP_100;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    real_d  = real_q;
    prev_d  = prev_q;
    rem_d   = rem_q;
    unique case (state_q)
      sjf_pkg::B_IDLE: begin
        if (start_i) begin
          a_d     = (alpha_i > sjf_pkg::PERCENT_SCALE) ? sjf_pkg::PERCENT_SCALE : alpha_i;
          real_d  = real_i;
          prev_d  = prev_i;
          state_d = sjf_pkg::B_MUL;
        end
      end
      sjf_pkg::B_MUL: begin
        rem_d   = prod[sjf_pkg::SUM_W-1:0];
        state_d = sjf_pkg::B_ADD;
      end
      sjf_pkg::B_ADD: begin
        rem_d   = rem_q + prod[sjf_pkg::SUM_W-1:0];
        state_d = sjf_pkg::B_DIV;
      end
      sjf_pkg::B_DIV: begin
        state_d = sjf_pkg::B_IDLE;
      end
      default: state_d = sjf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sjf_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    real_q <= real_d;
    prev_q <= prev_d;
    rem_q  <= rem_d;
  end

endmodule

// ===== src/sjf_ready_table_scheduler.sv =====
// Admit, tick, release, refused or unknown items: S_EXEC, S_EMIT; requeue adds S_BLEND
// (estimate unit B_MUL, B_ADD, B_DIV). Schedule: S_SCAN reads and compares entries, then
// S_DECIDE, S_SHIFT closes the gap, S_BLEND requeues any running process, S_EMIT loads
// the result. One item at a time: the next item is accepted in the cycle after its result
// is loaded; a result held on the output stalls only the next item's result. Reset clears
// control and running process and presets config; ready list contents are not cleared.
module sjf_ready_table_scheduler #(
  parameter int unsigned READY_SLOTS = sjf_pkg::READY_SLOTS_DEF,
  parameter int unsigned ID_BITS     = sjf_pkg::ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic [ID_BITS-1:0]          proc_id_i,
  input  logic [sjf_pkg::EST_W-1:0]   prev_estimate_i,
  input  logic [sjf_pkg::EST_W-1:0]   real_burst_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [ID_BITS-1:0]          out_id_o,
  output logic [sjf_pkg::EST_W-1:0]   out_estimate_o,
  output logic [sjf_pkg::EST_W-1:0]   out_executed_o,
  output logic                        kept_running_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sjf_pkg::PADDR_W-1:0] paddr,
  input  logic [sjf_pkg::DATA_W-1:0]  pwdata,
  output logic [sjf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned IDX_W = $clog2(READY_SLOTS);
  localparam int unsigned CNT_W = $clog2(READY_SLOTS + 1);
  localparam int unsigned ENT_W = ID_BITS + sjf_pkg::EST_W;
  localparam int unsigned EW    = sjf_pkg::EST_W;

  // configuration
  logic                         mode_q;
  logic [sjf_pkg::ALPHA_W-1:0]  alpha_q;
  logic [EW-1:0]                init_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      alpha_q <= sjf_pkg::ALPHA_RESET;
      init_q  <= sjf_pkg::INIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sjf_pkg::REG_MODE:  mode_q  <= pwdata[0];
        sjf_pkg::REG_ALPHA: alpha_q <= pwdata[sjf_pkg::ALPHA_W-1:0];
        sjf_pkg::REG_INIT:  init_q  <= pwdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sjf_pkg::REG_MODE:  prdata = sjf_pkg::DATA_W'(mode_q);
      sjf_pkg::REG_ALPHA: prdata = sjf_pkg::DATA_W'(alpha_q);
      sjf_pkg::REG_INIT:  prdata = sjf_pkg::DATA_W'(init_q);
      default:            prdata = '0;
    endcase
  end

  // control and state
  sjf_pkg::fsm_e       state_q, state_d;
  sjf_pkg::cmd_e       cmd_q;
  logic [ID_BITS-1:0]  pid_q;
  logic [EW-1:0]       prev_q, real_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                run_vld_q, run_vld_d;
  logic [ID_BITS-1:0]  run_id_q, run_id_d;
  logic [EW-1:0]       run_est_q, run_est_d;
  logic [EW-1:0]       run_exe_q, run_exe_d;

  logic [CNT_W-1:0]    scan_q, scan_d;
  logic                rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [ID_BITS-1:0]  best_id_q, best_id_d;
  logic [EW-1:0]       best_est_q, best_est_d;

  sjf_pkg::status_e    res_st_q, res_st_d;
  logic [ID_BITS-1:0]  res_id_q, res_id_d;
  logic [EW-1:0]       res_est_q, res_est_d;
  logic [EW-1:0]       res_exe_q, res_exe_d;
  logic                res_kept_q, res_kept_d;

  logic                out_vld_q, out_vld_d;
  sjf_pkg::status_e    out_st_q;
  logic [ID_BITS-1:0]  out_id_q;
  logic [EW-1:0]       out_est_q, out_exe_q;
  logic                out_kept_q;
  logic                out_load;

  // ready list RAM
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0]    mem_wdata, mem_rdata;
  logic [ID_BITS-1:0]  rd_id;
  logic [EW-1:0]       rd_est;

  assign rd_id  = mem_rdata[EW +: ID_BITS];
  assign rd_est = mem_rdata[EW-1:0];

  sjf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (READY_SLOTS)
  ) u_ready_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // estimate unit, shared by requeue and preemption
  logic           blend_start, blend_done;
  logic [EW-1:0]  blend_real, blend_prev, blend_res;

  assign blend_real = (cmd_q == sjf_pkg::CMD_REQUEUE) ? real_q : run_exe_q;
  assign blend_prev = (cmd_q == sjf_pkg::CMD_REQUEUE) ? prev_q : run_est_q;

  sjf_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (blend_start),
    .alpha_i  (alpha_q),
    .real_i   (blend_real),
    .prev_i   (blend_prev),
    .done_o   (blend_done),
    .result_o (blend_res)
  );

  logic              full, issue;
  logic [EW:0]       remaining;
  logic              keep_run;
  logic [EW-1:0]     exe_inc;

  assign full      = (count_q == CNT_W'(READY_SLOTS));
  assign issue     = (scan_q < count_q);
  assign remaining = {1'b0, run_est_q} - {1'b0, run_exe_q};
  assign keep_run  = $signed(remaining) < $signed({1'b0, best_est_q});
  assign exe_inc   = (run_exe_q == sjf_pkg::EST_MAX) ? run_exe_q : run_exe_q + EW'(1);
  assign in_ready_o = (state_q == sjf_pkg::S_IDLE);
  assign out_load   = (state_q == sjf_pkg::S_EMIT) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    run_vld_d  = run_vld_q;
    run_id_d   = run_id_q;
    run_est_d  = run_est_q;
    run_exe_d  = run_exe_q;
    scan_d     = scan_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    best_idx_d = best_idx_q;
    best_id_d  = best_id_q;
    best_est_d = best_est_q;
    res_st_d   = res_st_q;
    res_id_d   = res_id_q;
    res_est_d  = res_est_q;
    res_exe_d  = res_exe_q;
    res_kept_d = res_kept_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[IDX_W-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = scan_q[IDX_W-1:0];
    blend_start = 1'b0;

    unique case (state_q)
      sjf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = sjf_pkg::S_EXEC;
        end
      end

      sjf_pkg::S_EXEC: begin
        res_st_d   = sjf_pkg::ST_OK;
        res_id_d   = '0;
        res_est_d  = '0;
        res_exe_d  = '0;
        res_kept_d = 1'b0;
        state_d    = sjf_pkg::S_EMIT;
        unique case (cmd_q)
          sjf_pkg::CMD_ADMIT: begin
            res_id_d = pid_q;
            if (full) begin
              res_st_d = sjf_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {pid_q, init_q};
              count_d   = count_q + CNT_W'(1);
              res_est_d = init_q;
            end
          end
          sjf_pkg::CMD_REQUEUE: begin
            res_id_d = pid_q;
            if (full) begin
              res_st_d = sjf_pkg::ST_FULL;
            end else begin
              blend_start = 1'b1;
              state_d     = sjf_pkg::S_BLEND;
            end
          end
          sjf_pkg::CMD_SCHEDULE: begin
            if (count_q == '0) begin
              res_st_d = sjf_pkg::ST_EMPTY;
            end else if (run_vld_q && !mode_q) begin
              res_id_d   = run_id_q;
              res_est_d  = run_est_q;
              res_exe_d  = run_exe_q;
              res_kept_d = 1'b1;
            end else begin
              scan_d   = '0;
              rd_vld_d = 1'b0;
              state_d  = sjf_pkg::S_SCAN;
            end
          end
          sjf_pkg::CMD_TICK: begin
            if (!run_vld_q) begin
              res_st_d = sjf_pkg::ST_NONE;
            end else begin
              run_exe_d = exe_inc;
              res_id_d  = run_id_q;
              res_est_d = run_est_q;
              res_exe_d = exe_inc;
            end
          end
          sjf_pkg::CMD_RELEASE: begin
            if (!run_vld_q) begin
              res_st_d = sjf_pkg::ST_NONE;
            end else begin
              res_id_d  = run_id_q;
              res_est_d = run_est_q;
              res_exe_d = run_exe_q;
              run_vld_d = 1'b0;
              run_id_d  = '0;
              run_est_d = '0;
              run_exe_d = '0;
            end
          end
          default: ;
        endcase
      end

      // one slot read per cycle, compared in the cycle after; strict less keeps the earliest
      sjf_pkg::S_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          scan_d   = scan_q + CNT_W'(1);
          rd_idx_d = scan_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          if (rd_idx_q == '0 || rd_est < best_est_q) begin
            best_idx_d = rd_idx_q;
            best_id_d  = rd_id;
            best_est_d = rd_est;
          end
          if (CNT_W'(rd_idx_q) + CNT_W'(1) == count_q) begin
            state_d = sjf_pkg::S_DECIDE;
          end
        end
      end

      sjf_pkg::S_DECIDE: begin
        if (run_vld_q && keep_run) begin
          res_st_d   = sjf_pkg::ST_OK;
          res_id_d   = run_id_q;
          res_est_d  = run_est_q;
          res_exe_d  = run_exe_q;
          res_kept_d = 1'b1;
          state_d    = sjf_pkg::S_EMIT;
        end else begin
          scan_d   = CNT_W'(best_idx_q) + CNT_W'(1);
          rd_vld_d = 1'b0;
          state_d  = sjf_pkg::S_SHIFT;
        end
      end

      // close the gap left by the chosen entry: read slot k, write it to k-1
      sjf_pkg::S_SHIFT: begin
        rd_vld_d = issue;
        if (issue) begin
          scan_d   = scan_q + CNT_W'(1);
          rd_idx_d = scan_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx_q - IDX_W'(1);
          mem_wdata = mem_rdata;
        end
        if (!issue && !rd_vld_q) begin
          count_d = count_q - CNT_W'(1);
          if (run_vld_q) begin
            blend_start = 1'b1;
            state_d     = sjf_pkg::S_BLEND;
          end else begin
            run_vld_d  = 1'b1;
            run_id_d   = best_id_q;
            run_est_d  = best_est_q;
            run_exe_d  = '0;
            res_st_d   = sjf_pkg::ST_OK;
            res_id_d   = best_id_q;
            res_est_d  = best_est_q;
            res_exe_d  = '0;
            res_kept_d = 1'b0;
            state_d    = sjf_pkg::S_EMIT;
          end
        end
      end

      sjf_pkg::S_BLEND: begin
        if (blend_done) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          res_st_d   = sjf_pkg::ST_OK;
          res_exe_d  = '0;
          res_kept_d = 1'b0;
          state_d    = sjf_pkg::S_EMIT;
          if (cmd_q == sjf_pkg::CMD_SCHEDULE) begin
            mem_wdata = {run_id_q, blend_res};
            run_vld_d = 1'b1;
            run_id_d  = best_id_q;
            run_est_d = best_est_q;
            run_exe_d = '0;
            res_id_d  = best_id_q;
            res_est_d = best_est_q;
          end else begin
            mem_wdata = {pid_q, blend_res};
            res_id_d  = pid_q;
            res_est_d = blend_res;
          end
        end
      end

      sjf_pkg::S_EMIT: begin
        if (out_load) begin
          state_d = sjf_pkg::S_IDLE;
        end
      end

      default: state_d = sjf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sjf_pkg::S_IDLE;
      count_q   <= '0;
      run_vld_q <= 1'b0;
      run_id_q  <= '0;
      run_est_q <= '0;
      run_exe_q <= '0;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      run_vld_q <= run_vld_d;
      run_id_q  <= run_id_d;
      run_est_q <= run_est_d;
      run_exe_q <= run_exe_d;
      scan_q    <= scan_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= sjf_pkg::cmd_e'(cmd_i);
      pid_q  <= proc_id_i;
      prev_q <= prev_estimate_i;
      real_q <= real_burst_i;
    end
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_id_q  <= best_id_d;
    best_est_q <= best_est_d;
    res_st_q   <= res_st_d;
    res_id_q   <= res_id_d;
    res_est_q  <= res_est_d;
    res_exe_q  <= res_exe_d;
    res_kept_q <= res_kept_d;
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_id_q   <= res_id_q;
      out_est_q  <= res_est_q;
      out_exe_q  <= res_exe_q;
      out_kept_q <= res_kept_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_st_q;
  assign out_id_o       = out_id_q;
  assign out_estimate_o = out_est_q;
  assign out_executed_o = out_exe_q;
  assign kept_running_o = out_kept_q;

endmodule
